// ===== src/lcdser_pkg.sv =====
// Package for the LCD two-wire nibble serializer.
// Holds the request kinds, the queued request type and the row base constants.
// No dependencies.
package lcdser_pkg;

    // Request kinds carried on the input tuser field
    typedef enum logic [1:0] {
        MODE_CMD    = 2'd0,
        MODE_DATA   = 2'd1,
        MODE_INIT   = 2'd2,
        MODE_CURSOR = 2'd3
    } mode_t;

    // DDRAM address commands for the first two rows
    localparam logic [7:0] ROW0_BASE = 8'h80;
    localparam logic [7:0] ROW1_BASE = 8'hC0;

    // Index of the closing step
    localparam logic [5:0] LAST_STEP_BYTE = 6'd32;
    localparam logic [5:0] LAST_STEP_INIT = 6'd16;

    // Request as it sits in the queue between front and back
    typedef struct packed {
        logic [7:0] byte_value;
        logic       rs;
        logic       two_nibbles;
    } req_t;

endpackage

// ===== src/lcd_two_wire_nibble_serializer_top.sv =====
// LCD two-wire nibble serializer, top level.
// A byte request emits 33 steps and an init request 17, one step per cycle
// with m_axis_tready high; the back sequencer sets that rate. Requests wait
// in a two-entry queue; their steps leave through the output register.
// Out-of-range cursor requests are accepted and dropped. Synchronous
// active-low reset empties the queue and the output register.
module lcd_two_wire_nibble_serializer_top #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // byte_value[7:0], column[12:8], row[14:13], zero
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // data_line[0], clock_pulse[1], zero
    output logic        m_axis_tlast
);

    logic             keep;
    lcdser_pkg::req_t front_req;
    lcdser_pkg::req_t head_req;
    logic             full, not_empty, pop, push;
    logic             data_line, clock_pulse;

    assign s_axis_tready = !full;
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign m_axis_tdata  = {6'd0, clock_pulse, data_line};

    lcdser_front #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_front (
        .mode      (lcdser_pkg::mode_t'(s_axis_tuser)),
        .byte_value(s_axis_tdata[7:0]),
        .column    (s_axis_tdata[12:8]),
        .row       (s_axis_tdata[14:13]),
        .keep      (keep),
        .req       (front_req)
    );

    lcdser_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (front_req),
        .full     (full),
        .pop      (pop),
        .not_empty(not_empty),
        .head_req (head_req)
    );

    lcdser_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req_valid      (not_empty),
        .req            (head_req),
        .req_pop        (pop),
        .out_valid      (m_axis_tvalid),
        .out_data_line  (data_line),
        .out_clock_pulse(clock_pulse),
        .out_last       (m_axis_tlast),
        .out_ready      (m_axis_tready)
    );

endmodule

// ===== src/lcdser_front.sv =====
// Front part of the serializer: classifies an incoming request.
// Turns cursor positions into commands and drops out-of-range positions.
// Depends on lcdser_pkg.
module lcdser_front #(
    parameter int COLUMNS = 16,
    parameter int ROWS    = 2
) (
    input  lcdser_pkg::mode_t mode,
    input  logic [7:0]        byte_value,
    input  logic [4:0]        column,
    input  logic [1:0]        row,
    output logic              keep,
    output lcdser_pkg::req_t  req
);

    localparam logic [4:0] ColLimit = 5'(COLUMNS);
    localparam logic [2:0] RowLimit = 3'(ROWS);
    localparam logic [7:0] ColOffset = 8'(COLUMNS);

    logic [7:0] row_base;
    logic [7:0] cursor_cmd;

    // Form the set-address command from row base plus column
    always_comb begin
        row_base   = (row[0] ? lcdser_pkg::ROW1_BASE : lcdser_pkg::ROW0_BASE)
                   + (row[1] ? ColOffset : 8'd0);
        cursor_cmd = row_base + {3'd0, column};
    end

    // Classify the request
    always_comb begin
        keep            = 1'b1;
        req.byte_value  = byte_value;
        req.rs          = 1'b0;
        req.two_nibbles = 1'b1;
        unique case (mode)
            lcdser_pkg::MODE_CMD: begin
            end
            lcdser_pkg::MODE_DATA: begin
                req.rs = 1'b1;
            end
            lcdser_pkg::MODE_INIT: begin
                req.two_nibbles = 1'b0;
            end
            lcdser_pkg::MODE_CURSOR: begin
                req.byte_value = cursor_cmd;
                keep = (column < ColLimit) && ({1'b0, row} < RowLimit);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/lcdser_queue.sv =====
// Two-entry request queue between front and back.
// Push and pop may happen in the same cycle.
// Depends on lcdser_pkg.
module lcdser_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  lcdser_pkg::req_t push_req,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output lcdser_pkg::req_t head_req
);

    lcdser_pkg::req_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_req  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request payload
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// ===== src/lcdser_back.sv =====
// Back part of the serializer: walks the pin steps of the head request.
// One step a cycle into an output register unless out_ready stalls it;
// pops the queue on the last step. Depends on lcdser_pkg.
module lcdser_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             req_valid,
    input  lcdser_pkg::req_t req,
    output logic             req_pop,
    output logic             out_valid,
    output logic             out_data_line,
    output logic             out_clock_pulse,
    output logic             out_last,
    input  logic             out_ready
);

    logic [5:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    logic       data_reg, clock_reg, last_reg;
    logic       load;
    logic       final_step;
    logic [3:0] phase_step;
    logic [3:0] nibble;
    logic       step_data, step_clock;

    assign out_valid       = valid_reg;
    assign out_data_line   = data_reg;
    assign out_clock_pulse = clock_reg;
    assign out_last        = last_reg;

    // Load a new step whenever the output register is free or drained
    assign load       = req_valid && (!valid_reg || out_ready);
    assign final_step = (step_reg == (req.two_nibbles ? lcdser_pkg::LAST_STEP_BYTE
                                                      : lcdser_pkg::LAST_STEP_INIT));
    assign req_pop    = load && final_step;
    assign phase_step = step_reg[3:0];
    assign nibble     = step_reg[4] ? req.byte_value[3:0] : req.byte_value[7:4];

    // Decode the pin levels of the current step
    always_comb begin
        step_data  = 1'b0;
        step_clock = 1'b1;
        if (final_step) begin
            step_clock = 1'b0;
        end else begin
            unique case (phase_step)
                4'd0:  step_clock = 1'b0;            // data low, no clock
                4'd8:  step_data  = 1'b1;            // E bit
                4'd9:  step_data  = req.rs;          // RS bit
                4'd10: step_data  = nibble[3];
                4'd11: step_data  = nibble[2];
                4'd12: step_data  = nibble[1];
                4'd13: step_data  = nibble[0];
                4'd15: begin                         // strobe
                    step_data  = 1'b1;
                    step_clock = 1'b0;
                end
                default: step_data = 1'b0;           // clear clocks and zero clock
            endcase
        end
    end

    // Advance the step counter and output valid
    always_comb begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (load) begin
            step_next  = final_step ? 6'd0 : step_reg + 6'd1;
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= 6'd0;
            valid_reg <= 1'b0;
        end else begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    // Hold the step payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg  <= step_data;
            clock_reg <= step_clock;
            last_reg  <= final_step;
        end
    end

endmodule

// ===== tb/sv/lcdser_tb_pkg.sv =====
`timescale 1ns / 100ps
// Pin step scoreboard for the LCD two-wire nibble serializer testbench.
// Predicts the serial pin steps of each accepted request and checks the results.
// Depends on lcdser_pkg for the request kinds and the row base commands.
package lcdser_tb_pkg;

    localparam int DISPLAY_COLUMNS = 16;
    localparam int DISPLAY_ROWS    = 2;

    // One pin step as it is expected on the result channel
    typedef struct packed {
        logic data_line;
        logic clock_pulse;
        logic last;
    } pin_step_t;

    class pin_step_scoreboard;
        pin_step_t   expected_steps[$];
        int unsigned errors;
        int unsigned steps_checked;
        int unsigned requests_noted;
        int unsigned cursors_dropped;

        function new();
            errors          = 0;
            steps_checked   = 0;
            requests_noted  = 0;
            cursors_dropped = 0;
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        function void push_step(bit data_line, bit clock_pulse, bit last);
            pin_step_t step;
            step.data_line   = data_line;
            step.clock_pulse = clock_pulse;
            step.last        = last;
            expected_steps.push_back(step);
        endfunction

        // Queue one nibble phase: clear, E bit, RS, four bits MSB first, zero, strobe
        function void push_phase(bit rs, logic [3:0] nibble);
            push_step(1'b0, 1'b0, 1'b0);
            repeat (7) push_step(1'b0, 1'b1, 1'b0);
            push_step(1'b1, 1'b1, 1'b0);
            push_step(rs, 1'b1, 1'b0);
            for (int i = 3; i >= 0; i--) begin
                push_step(nibble[i], 1'b1, 1'b0);
            end
            push_step(1'b0, 1'b1, 1'b0);
            push_step(1'b1, 1'b0, 1'b0);
        endfunction

        // Predict every pin step that an accepted request causes
        function void note_request(lcdser_pkg::mode_t mode, logic [7:0] byte_value,
                                   logic [4:0] column, logic [1:0] row);
            logic [7:0] sent_byte;
            bit         rs;
            sent_byte = byte_value;
            requests_noted++;
            if (mode == lcdser_pkg::MODE_CURSOR) begin
                // Drop a position outside the display
                if (column >= DISPLAY_COLUMNS || row >= DISPLAY_ROWS) begin
                    cursors_dropped++;
                    return;
                end
                case (row)
                    2'd0: sent_byte = lcdser_pkg::ROW0_BASE;
                    2'd1: sent_byte = lcdser_pkg::ROW1_BASE;
                    2'd2: sent_byte = lcdser_pkg::ROW0_BASE + 8'(DISPLAY_COLUMNS);
                    default: sent_byte = lcdser_pkg::ROW1_BASE + 8'(DISPLAY_COLUMNS);
                endcase
                sent_byte = sent_byte + {3'b000, column};
            end
            rs = (mode == lcdser_pkg::MODE_DATA);
            push_phase(rs, sent_byte[7:4]);
            if (mode != lcdser_pkg::MODE_INIT) begin
                push_phase(rs, sent_byte[3:0]);
            end
            push_step(1'b0, 1'b0, 1'b1);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        // Check one accepted pin step against the oldest expectation
        function void check_step(logic [7:0] tdata, logic tlast);
            pin_step_t want;
            if (expected_steps.size() == 0) begin
                errors++;
                $display("%0t: unexpected pin step, expected none, actual data %0h last %0b",
                         $time, tdata, tlast);
                return;
            end
            want = expected_steps.pop_front();
            steps_checked++;
            compare_field("data_line", {7'd0, want.data_line}, {7'd0, tdata[0]});
            compare_field("clock_pulse", {7'd0, want.clock_pulse}, {7'd0, tdata[1]});
            compare_field("last", {7'd0, want.last}, {7'd0, tlast});
            compare_field("tdata padding", 8'd0, {2'b00, tdata[7:2]});
        endfunction
    endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Top testbench for the LCD two-wire nibble serializer: drives requests,
// stalls both channels at random and checks every pin step against a scoreboard.
// Depends on lcdser_pkg, lcdser_tb_pkg and lcd_two_wire_nibble_serializer_top.
module tb;

    localparam int IDLE_LIMIT       = 3000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 40;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;
    logic [1:0]  s_axis_tuser  = 2'd0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic rx_holding  = 1'b0;
    int   idle_cycles = 0;
    event start_long_hold;

    lcdser_tb_pkg::pin_step_scoreboard sb = new();

    lcd_two_wire_nibble_serializer_top #(
        .COLUMNS(lcdser_tb_pkg::DISPLAY_COLUMNS),
        .ROWS(lcdser_tb_pkg::DISPLAY_ROWS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Note accepted requests
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            sb.note_request(lcdser_pkg::mode_t'(s_axis_tuser), s_axis_tdata[7:0],
                            s_axis_tdata[12:8], s_axis_tdata[14:13]);
        end
    end

    // Check accepted pin steps
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            sb.check_step(m_axis_tdata, m_axis_tlast);
        end
    end

    // Drive the receiver ready, stalling at random or for a long hold
    always @(posedge aclk) begin
        if (rx_holding) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Hold the receiver off for a long stretch on request
    initial begin
        forever begin
            @(start_long_hold);
            rx_holding <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge aclk);
            rx_holding <= 1'b0;
        end
    end

    // End the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Offer one request, idling first at random, and wait for its handshake
    task automatic send_request(lcdser_pkg::mode_t mode, logic [7:0] byte_value,
                                logic [4:0] column, logic [1:0] row);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, row, column, byte_value};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Mostly well-formed requests, with some cursor positions off the display
    task automatic send_random(int count);
        lcdser_pkg::mode_t mode;
        logic [4:0]        column;
        logic [1:0]        row;
        repeat (count) begin
            mode   = lcdser_pkg::mode_t'(2'($urandom_range(3)));
            column = 5'($urandom_range(31));
            row    = 2'($urandom_range(3));
            if (mode == lcdser_pkg::MODE_CURSOR && $urandom_range(99) < 80) begin
                column = 5'($urandom_range(lcdser_tb_pkg::DISPLAY_COLUMNS - 1));
                row    = 2'($urandom_range(lcdser_tb_pkg::DISPLAY_ROWS - 1));
            end
            send_request(mode, 8'($urandom_range(255)), column, row);
        end
    endtask

    // Stop offering and wait until every expected step has come
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles often, receiver more
        tx_idle_pct = 33;
        rx_idle_pct <= 58;

        // Byte extremes for each request kind
        send_request(lcdser_pkg::MODE_CMD,    8'h00, 5'd0,  2'd0);
        send_request(lcdser_pkg::MODE_CMD,    8'hFF, 5'd0,  2'd0);
        send_request(lcdser_pkg::MODE_CMD,    8'h28, 5'd0,  2'd0);
        send_request(lcdser_pkg::MODE_DATA,   8'h00, 5'd0,  2'd0);
        send_request(lcdser_pkg::MODE_DATA,   8'hFF, 5'd0,  2'd0);
        send_request(lcdser_pkg::MODE_DATA,   8'hA5, 5'd0,  2'd0);
        send_request(lcdser_pkg::MODE_DATA,   8'h5A, 5'd0,  2'd0);
        // Init sends the high nibble only
        send_request(lcdser_pkg::MODE_INIT,   8'h30, 5'd0,  2'd0);
        send_request(lcdser_pkg::MODE_INIT,   8'hF0, 5'd0,  2'd0);
        send_request(lcdser_pkg::MODE_INIT,   8'h0F, 5'd0,  2'd0);
        // Cursor positions at the corners; the byte is ignored
        send_request(lcdser_pkg::MODE_CURSOR, 8'hFF, 5'd0,  2'd0);
        send_request(lcdser_pkg::MODE_CURSOR, 8'h00, 5'd15, 2'd1);
        send_request(lcdser_pkg::MODE_CURSOR, 8'h5A, 5'd15, 2'd0);
        send_request(lcdser_pkg::MODE_CURSOR, 8'hA5, 5'd0,  2'd1);
        // Cursor off the display: column too large, row too large, both
        send_request(lcdser_pkg::MODE_CURSOR, 8'h00, 5'd16, 2'd0);
        send_request(lcdser_pkg::MODE_CURSOR, 8'h00, 5'd0,  2'd2);
        send_request(lcdser_pkg::MODE_CURSOR, 8'h00, 5'd7,  2'd3);
        send_request(lcdser_pkg::MODE_CURSOR, 8'hFF, 5'd31, 2'd3);
        // Position fields ignored outside cursor mode
        send_request(lcdser_pkg::MODE_CMD,    8'h01, 5'd31, 2'd3);
        send_request(lcdser_pkg::MODE_DATA,   8'h80, 5'd31, 2'd3);
        send_random(40);
        wait_drained();

        // Receiver idles less than the sender
        tx_idle_pct = 58;
        rx_idle_pct <= 33;
        send_random(40);
        wait_drained();

        // No idling; hold the receiver off so the input stalls
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        -> start_long_hold;
        send_random(30);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Covered %0d requests (%0d off-display cursors), %0d pin steps, %0d errors",
                 sb.requests_noted, sb.cursors_dropped, sb.steps_checked, sb.errors);
        $display("Exercised command, data, init and cursor modes under three stall mixes");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb OK");
        end else begin
            if (sb.pending() != 0) begin
                $display("%0t: %0d expected pin steps never arrived", $time, sb.pending());
            end
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/lcdser_pkg.sv
src/lcdser_front.sv
src/lcdser_queue.sv
src/lcdser_back.sv
src/lcd_two_wire_nibble_serializer_top.sv
tb/sv/lcdser_tb_pkg.sv
tb/sv/tb.sv
